// ===== rtl/sll_pkg.sv =====
// package: sizes, codes and word types of the sorted linked list engine
package sll_pkg;

  localparam int NODE_SLOTS = 64;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(NODE_SLOTS);
  localparam int LINK_W     = $clog2(NODE_SLOTS + 1);

  // sentinel lives one past the last node slot
  localparam logic [LINK_W-1:0]   SENT    = LINK_W'(NODE_SLOTS);
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

  localparam logic [1:0] OP_SORTED = 2'd0;
  localparam logic [1:0] OP_TAIL   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK_A,
    ST_LINK_B,
    ST_UNLINK,
    ST_HEAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [5:0]          node;
    logic [KEY_BITS-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [6:0]          count;
    logic                error;
    logic                head_valid;
    logic [5:0]          head_node;
    logic [KEY_BITS-1:0] head_key;
  } result_t;

endpackage

// ===== rtl/sll_ram.sv =====
// generic single write port ram with registered read
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/sorted_linked_list_engine.sv =====
// top level: sorted doubly linked list engine over a pool of node slots
//
//   channel  | ports                  | handshake
//   ---------+------------------------+----------------------------------------
//   command  | start, busy, cmd       | word taken at an edge with start & !busy
//   result   | done, result           | word valid for exactly one cycle on done
//
// a sorted insert below KEY_MAX into a non-empty list walks from the head, comparing node keys;
// the walk reads one node per cycle from the link and key rams
// the next word can be taken in the cycle after the done cycle, when busy has dropped
// reset clears the linked flags, the count and the sentinel links at once: no
// clearing pass; node links are only read once written, keys too but for a slot tail-inserted unkeyed
// the receiver cannot stall; busy stays high from acceptance until done
module sorted_linked_list_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sll_pkg::cmd_t   cmd,
  output logic            done,
  output sll_pkg::result_t result
);

  localparam int IW = sll_pkg::IDX_W;
  localparam int LW = sll_pkg::LINK_W;
  localparam int KW = sll_pkg::KEY_BITS;

  sll_pkg::state_t state, state_next;

  // the captured command word
  logic [1:0]    op_r;
  logic [IW-1:0] node_r;
  logic [KW-1:0] key_r;
  logic          err_r;

  // walk position: insert goes between it_ptr and cur_ptr
  logic [LW-1:0] it_ptr;
  logic [LW-1:0] cur_ptr;

  // sentinel links held in flops
  logic [LW-1:0] sent_next;
  logic [LW-1:0] sent_prev;

  logic [sll_pkg::NODE_SLOTS-1:0] linked;
  logic [LW-1:0]                  count;

  // shared read address for the three rams
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;
  logic [KW-1:0] key_rd;

  logic          next_we, prev_we, key_we;
  logic [IW-1:0] next_wa, prev_wa;
  logic [LW-1:0] next_wd, prev_wd;

  logic accept;
  logic node_ok;
  logic cmd_err;
  logic walk_on;

  assign accept  = start && (state == sll_pkg::ST_IDLE);
  assign busy    = (state != sll_pkg::ST_IDLE);
  assign node_ok = (32'(cmd.node) < sll_pkg::NODE_SLOTS);

  // insert of a linked node or remove of an unlinked one is turned away
  always_comb begin
    cmd_err = 1'b0;
    case (cmd.operation)
      sll_pkg::OP_CLEAR:  cmd_err = 1'b0;
      sll_pkg::OP_REMOVE: cmd_err = !node_ok || !linked[cmd.node[IW-1:0]];
      default:            cmd_err = !node_ok || linked[cmd.node[IW-1:0]];
    endcase
  end

  // keep walking while the candidate key is not above the new key
  assign walk_on = (key_rd <= key_r);

  // link rams: node slots only, the sentinel sits in flops
  sll_ram #(.WIDTH(LW), .DEPTH(sll_pkg::NODE_SLOTS)) u_next_ram (
    .clk     (clk),
    .we      (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_addr (rd_addr),
    .rd_data (next_rd)
  );

  sll_ram #(.WIDTH(LW), .DEPTH(sll_pkg::NODE_SLOTS)) u_prev_ram (
    .clk     (clk),
    .we      (prev_we),
    .wr_addr (prev_wa),
    .wr_data (prev_wd),
    .rd_addr (rd_addr),
    .rd_data (prev_rd)
  );

  sll_ram #(.WIDTH(KW), .DEPTH(sll_pkg::NODE_SLOTS)) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .wr_addr (node_r),
    .wr_data (key_r),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sll_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, ram addressing and write strobes
  always_comb begin
    state_next = state;
    rd_addr    = sent_next[IW-1:0];
    next_we    = 1'b0;
    prev_we    = 1'b0;
    key_we     = 1'b0;
    next_wa    = node_r;
    prev_wa    = node_r;
    next_wd    = cur_ptr;
    prev_wd    = it_ptr;
    case (state)
      sll_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.operation == sll_pkg::OP_REMOVE) begin
            rd_addr = cmd.node[IW-1:0];
          end
          if (cmd_err || cmd.operation == sll_pkg::OP_CLEAR) begin
            state_next = sll_pkg::ST_HEAD;
          end else if (cmd.operation == sll_pkg::OP_REMOVE) begin
            state_next = sll_pkg::ST_UNLINK;
          end else if (cmd.operation == sll_pkg::OP_SORTED && cmd.key != sll_pkg::KEY_MAX
                       && sent_next != sll_pkg::SENT) begin
            // first candidate is the head, read its key and link now
            state_next = sll_pkg::ST_WALK;
          end else begin
            state_next = sll_pkg::ST_LINK_A;
          end
        end
      end
      sll_pkg::ST_WALK: begin
        rd_addr = next_rd[IW-1:0];
        if (!walk_on || next_rd == sll_pkg::SENT) begin
          state_next = sll_pkg::ST_LINK_A;
        end
      end
      sll_pkg::ST_LINK_A: begin
        // new node points both ways
        next_we    = 1'b1;
        prev_we    = 1'b1;
        key_we     = (op_r == sll_pkg::OP_SORTED);
        state_next = sll_pkg::ST_LINK_B;
      end
      sll_pkg::ST_LINK_B: begin
        // neighbours point at the new node
        next_we    = (it_ptr != sll_pkg::SENT);
        next_wa    = it_ptr[IW-1:0];
        next_wd    = LW'(node_r);
        prev_we    = (cur_ptr != sll_pkg::SENT);
        prev_wa    = cur_ptr[IW-1:0];
        prev_wd    = LW'(node_r);
        state_next = sll_pkg::ST_HEAD;
      end
      sll_pkg::ST_UNLINK: begin
        // neighbours of the removed node point past it
        next_we    = (prev_rd != sll_pkg::SENT);
        next_wa    = prev_rd[IW-1:0];
        next_wd    = next_rd;
        prev_we    = (next_rd != sll_pkg::SENT);
        prev_wa    = next_rd[IW-1:0];
        prev_wd    = prev_rd;
        state_next = sll_pkg::ST_HEAD;
      end
      sll_pkg::ST_HEAD: begin
        // fetch the key of the head for the result word
        rd_addr    = sent_next[IW-1:0];
        state_next = sll_pkg::ST_DONE;
      end
      sll_pkg::ST_DONE: begin
        state_next = sll_pkg::ST_IDLE;
      end
      default: begin
        state_next = sll_pkg::ST_IDLE;
      end
    endcase
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_next <= sll_pkg::SENT;
      sent_prev <= sll_pkg::SENT;
      linked    <= '0;
      count     <= '0;
    end else begin
      case (state)
        sll_pkg::ST_IDLE: begin
          if (accept && cmd.operation == sll_pkg::OP_CLEAR) begin
            sent_next <= sll_pkg::SENT;
            sent_prev <= sll_pkg::SENT;
            linked    <= '0;
            count     <= '0;
          end
        end
        sll_pkg::ST_LINK_A: begin
          linked[node_r] <= 1'b1;
        end
        sll_pkg::ST_LINK_B: begin
          if (it_ptr == sll_pkg::SENT) begin
            sent_next <= LW'(node_r);
          end
          if (cur_ptr == sll_pkg::SENT) begin
            sent_prev <= LW'(node_r);
          end
          count <= count + LW'(1);
        end
        sll_pkg::ST_UNLINK: begin
          if (prev_rd == sll_pkg::SENT) begin
            sent_next <= next_rd;
          end
          if (next_rd == sll_pkg::SENT) begin
            sent_prev <= prev_rd;
          end
          linked[node_r] <= 1'b0;
          count          <= count - LW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // command capture and walk pointers
  always_ff @(posedge clk) begin
    case (state)
      sll_pkg::ST_IDLE: begin
        if (accept) begin
          op_r   <= cmd.operation;
          node_r <= cmd.node[IW-1:0];
          key_r  <= cmd.key;
          err_r  <= cmd_err;
          if (cmd.operation == sll_pkg::OP_SORTED && cmd.key != sll_pkg::KEY_MAX) begin
            it_ptr  <= sll_pkg::SENT;
            cur_ptr <= sent_next;
          end else begin
            // tail insert goes between the last node and the sentinel
            it_ptr  <= sent_prev;
            cur_ptr <= sll_pkg::SENT;
          end
        end
      end
      sll_pkg::ST_WALK: begin
        if (walk_on) begin
          it_ptr  <= cur_ptr;
          cur_ptr <= next_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  assign done              = (state == sll_pkg::ST_DONE);
  assign result.count      = 7'(count);
  assign result.error      = err_r;
  assign result.head_valid = (count != '0);
  assign result.head_node  = (count != '0) ? 6'(sent_next[IW-1:0]) : 6'd0;
  assign result.head_key   = (count != '0) ? key_rd : '0;

  // an empty list is exactly a self-linked sentinel
  a_empty_link: assert property (@(posedge clk) disable iff (rst)
    (state == sll_pkg::ST_IDLE) |-> ((count == '0) == (sent_next == sll_pkg::SENT)))
    else $error("count and sentinel link disagree");

  // the walk never stands on the sentinel
  a_walk_node: assert property (@(posedge clk) disable iff (rst)
    (state == sll_pkg::ST_WALK) |-> (cur_ptr != sll_pkg::SENT))
    else $error("walk reached the sentinel");

  // a rejected word leaves the count alone
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    (state == sll_pkg::ST_HEAD && err_r) |-> $stable(count))
    else $error("rejected word changed the count");

  // done falls straight after its strobe, with busy low
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done strobe longer than one cycle");

endmodule

// ===== sim/sll_checker.sv =====
// checker: watches the command and result channels, predicts each result word and compares
module sll_checker
  import sll_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      fails,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the list: links, keys, membership and length
  logic [LINK_W-1:0]   fwd      [0:NODE_SLOTS];
  logic [LINK_W-1:0]   back     [0:NODE_SLOTS];
  logic [KEY_BITS-1:0] slot_key [0:NODE_SLOTS-1];
  bit   [NODE_SLOTS-1:0] on_list;
  logic [6:0]          tally;

  result_t due_q [$];
  result_t want;
  result_t predicted;

  // the sentinel reads as the largest key, KEY_MAX
  function automatic logic [KEY_BITS-1:0] key_at(input logic [LINK_W-1:0] idx);
    if (idx >= NODE_SLOTS) return KEY_MAX;
    return slot_key[idx[IDX_W-1:0]];
  endfunction

  task automatic empty_list();
    on_list    = '0;
    fwd[SENT]  = SENT;
    back[SENT] = SENT;
    tally      = '0;
  endtask

  task automatic splice_after(input logic [LINK_W-1:0] at, input logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] x;
    x         = fwd[at];
    fwd[n]    = x;
    back[x]   = n;
    back[n]   = at;
    fwd[at]   = n;
    on_list[n[IDX_W-1:0]] = 1'b1;
    tally++;
  endtask

  task automatic predict_word(input cmd_t w, output result_t r);
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] it;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] x;
    int                steps;
    logic              err;
    n   = LINK_W'(w.node);
    err = 1'b0;
    case (w.operation)
      OP_CLEAR: begin
        empty_list();
      end
      OP_REMOVE: begin
        if (!on_list[w.node]) begin
          err = 1'b1;
        end else begin
          p = back[n];
          x = fwd[n];
          fwd[p]  = x;
          back[x] = p;
          on_list[w.node] = 1'b0;
          tally--;
        end
      end
      OP_SORTED, OP_TAIL: begin
        if (on_list[w.node]) begin
          err = 1'b1;
        end else if (w.operation == OP_TAIL) begin
          splice_after(back[SENT], n);
        end else begin
          slot_key[w.node] = w.key;
          it = SENT;
          if (w.key == KEY_MAX) begin
            it = back[SENT];
          end else begin
            // equal keys go after the older ones
            steps = 0;
            while (steps <= NODE_SLOTS && key_at(fwd[it]) <= w.key) begin
              it = fwd[it];
              steps++;
            end
          end
          splice_after(it, n);
        end
      end
    endcase
    r.count = tally;
    r.error = err;
    if (tally != 0) begin
      r.head_valid = 1'b1;
      r.head_node  = fwd[SENT][5:0];
      r.head_key   = key_at(fwd[SENT]);
    end else begin
      r.head_valid = 1'b0;
      r.head_node  = '0;
      r.head_key   = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NODE_SLOTS; i++) begin
        fwd[i]  = '0;
        back[i] = '0;
      end
      for (int i = 0; i < NODE_SLOTS; i++) slot_key[i] = '0;
      empty_list();
      due_q.delete();
    end else begin
      if (done) begin
        if (due_q.size() == 0) begin
          $error("result word with none outstanding: %h", result);
          fails++;
        end else begin
          want = due_q.pop_front();
          check_field("count", 64'(want.count), 64'(result.count));
          check_field("error", 64'(want.error), 64'(result.error));
          check_field("head_valid", 64'(want.head_valid), 64'(result.head_valid));
          check_field("head_node", 64'(want.head_node), 64'(result.head_node));
          check_field("head_key", 64'(want.head_key), 64'(result.head_key));
        end
      end
      if (start && !busy) begin
        predict_word(cmd, predicted);
        due_q.push_back(predicted);
      end
    end
    pending = due_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: drives command words into the list engine and gives the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sll_pkg::*;

  localparam int RANDOM_WORDS = 1080;
  localparam int CYCLE_LIMIT  = 500000;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      fails;
  int      pending;
  int      cycles;

  // what the stimulus side believes is linked, and which slots have had a key stored;
  // a tail insert of a slot that never got a key would expose an unwritten key
  bit [NODE_SLOTS-1:0] stim_on;
  bit [NODE_SLOTS-1:0] key_set;
  int                  on_count;
  int                  target;

  sorted_linked_list_engine dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  sll_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .fails   (fails),
    .pending (pending)
  );

  always #1 clk = ~clk;

  // runaway guard: a stuck busy or a lost result word ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic cmd_t mk(input logic [1:0] op, input int node,
                              input logic [KEY_BITS-1:0] key);
    cmd_t w;
    w.operation = op;
    w.node      = node[5:0];
    w.key       = key;
    return w;
  endfunction

  // keys cluster on a few small values so that equal keys are common,
  // with the extremes and full-width values mixed in
  function automatic logic [KEY_BITS-1:0] random_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KEY_MAX;
      2:       return KEY_MAX - 1;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // random slot that is (or is not) on the list, scanning from a random start
  function automatic int pick_node(input bit linked);
    int s;
    int idx;
    s = $urandom_range(0, NODE_SLOTS - 1);
    for (int i = 0; i < NODE_SLOTS; i++) begin
      idx = (s + i) % NODE_SLOTS;
      if (stim_on[idx] == linked) return idx;
    end
    return s;
  endfunction

  // optional idle gap, then hold start with the word until an edge finds busy low;
  // busy read straight after the edge is still its value before that edge
  task automatic send_word(input cmd_t w, input int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (w.operation == OP_TAIL && !stim_on[w.node] && !key_set[w.node])
      w.operation = OP_SORTED;
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    // word taken at this edge: track the list as the engine will hold it
    case (w.operation)
      OP_SORTED: begin
        if (!stim_on[w.node]) begin
          stim_on[w.node] = 1'b1;
          key_set[w.node] = 1'b1;
          on_count++;
        end
      end
      OP_TAIL: begin
        if (!stim_on[w.node]) begin
          stim_on[w.node] = 1'b1;
          on_count++;
        end
      end
      OP_REMOVE: begin
        if (stim_on[w.node]) begin
          stim_on[w.node] = 1'b0;
          on_count--;
        end
      end
      OP_CLEAR: begin
        stim_on  = '0;
        on_count = 0;
      end
    endcase
  endtask

  initial begin
    cmd_t w;
    int   pct;
    int   sel;
    bit   grow;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-list errors, key extremes, equal keys, rejects, clear
    send_word(mk(OP_REMOVE, 5, 32'h0), 20);                // remove from an empty list
    send_word(mk(OP_CLEAR, 0, 32'h0), 20);                 // clear when already empty
    send_word(mk(OP_SORTED, 0, 32'h0), 20);                // smallest key
    send_word(mk(OP_SORTED, 63, KEY_MAX), 20);             // maximum key goes to the tail
    send_word(mk(OP_SORTED, 10, 32'd100), 20);
    send_word(mk(OP_SORTED, 11, 32'd100), 20);             // equal key lands after node 10
    send_word(mk(OP_SORTED, 12, 32'd50), 20);
    send_word(mk(OP_SORTED, 13, 32'h0), 20);               // equal to the head key
    send_word(mk(OP_SORTED, 10, 32'd7), 20);               // already linked: rejected
    send_word(mk(OP_TAIL, 11, 32'h0), 20);                 // already linked: rejected
    send_word(mk(OP_REMOVE, 0, 32'h0), 20);                // remove the head
    send_word(mk(OP_REMOVE, 63, 32'h0), 20);               // remove the tail
    send_word(mk(OP_TAIL, 63, 32'h0), 20);                 // tail insert keeps its old key
    send_word(mk(OP_TAIL, 0, KEY_MAX), 20);                // key field ignored on tail insert
    send_word(mk(OP_SORTED, 20, 32'h8000_0000), 20);
    send_word(mk(OP_REMOVE, 11, 32'h0), 20);               // remove from the middle
    send_word(mk(OP_REMOVE, 11, 32'h0), 20);               // not linked any more: rejected
    send_word(mk(OP_CLEAR, 63, KEY_MAX), 20);              // clear ignores node and key
    send_word(mk(OP_TAIL, 12, 32'h0), 20);                 // tail insert into an empty list
    send_word(mk(OP_SORTED, 1, KEY_MAX - 1), 20);          // just below the sentinel key
    send_word(mk(OP_SORTED, 2, KEY_MAX), 20);
    send_word(mk(OP_SORTED, 3, 32'h5555_AAAA), 20);
    send_word(mk(OP_REMOVE, 12, 32'h0), 20);

    // random: mostly well-formed inserts and removes steering the length toward a
    // moving target (full and empty included), the rest clears and random noise
    target = NODE_SLOTS;
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 20 : (ph == 1) ? 49 : 0;
      for (int i = 0; i < RANDOM_WORDS / 3; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          case ($urandom_range(0, 3))
            0:       target = 0;
            1:       target = NODE_SLOTS;
            default: target = $urandom_range(0, NODE_SLOTS);
          endcase
        end
        sel         = $urandom_range(0, 99);
        w.node      = 6'($urandom_range(0, NODE_SLOTS - 1));
        w.key       = $urandom;
        w.operation = OP_CLEAR;
        if (sel < 3) begin
          w.operation = OP_CLEAR;
        end else if (sel < 12) begin
          // noise: any operation but clear on any slot, rejects included
          w.operation = 2'($urandom_range(0, 2));
          w.key       = random_key();
        end else begin
          grow = (on_count < target) || (on_count == target && $urandom_range(0, 1) == 1);
          if (on_count == NODE_SLOTS) grow = 1'b0;
          if (on_count == 0) grow = 1'b1;
          if (grow) begin
            w.node      = 6'(pick_node(1'b0));
            w.key       = random_key();
            w.operation = ($urandom_range(0, 3) == 0 && key_set[w.node]) ? OP_TAIL : OP_SORTED;
          end else begin
            w.node      = 6'(pick_node(1'b1));
            w.operation = OP_REMOVE;
          end
        end
        send_word(w, pct);
      end
    end

    // drain: wait for the last result word, then a short quiet spell for strays
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sorted_linked_list_engine.f =====
rtl/sll_pkg.sv
rtl/sll_ram.sv
rtl/sorted_linked_list_engine.sv
sim/sll_checker.sv
sim/tb_top.sv
